// File: design/dmbm_pkg.sv
// ----------------------------------------------------------------------------
// Display mode best match: shared package
// Payload types, register indexes and reset values used across the design.
// ----------------------------------------------------------------------------
package dmbm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMustHave    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMustNotHave = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinGunBits  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinDepth    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinWidth    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinHeight   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReqModeId   = 3'd6;

  // Command codes.
  localparam logic CmdClear = 1'b0;
  localparam logic CmdOffer = 1'b1;

  // Reset values of the registers and of the kept state.
  localparam logic [31:0] MustHaveRst    = 32'h0000_0000;
  localparam logic [31:0] MustNotHaveRst = 32'h0000_0000;
  localparam logic [23:0] MinGunBitsRst  = 24'h04_0404;
  localparam logic [7:0]  MinDepthRst    = 8'd1;
  localparam logic [15:0] MinWidthRst    = 16'd640;
  localparam logic [15:0] MinHeightRst   = 16'd480;
  localparam logic [31:0] NoMode         = 32'hFFFF_FFFF;
  localparam logic [15:0] KeptSizeRst    = 16'hFFFF;

  typedef struct packed {
    logic        cmd;
    logic [31:0] mode_id;
    logic        unavailable;
    logic [31:0] property_flags;
    logic [7:0]  red_bits;
    logic [7:0]  green_bits;
    logic [7:0]  blue_bits;
    logic [7:0]  max_depth;
    logic [15:0] left_x;
    logic [15:0] right_x;
    logic [15:0] top_y;
    logic [15:0] bottom_y;
  } dmbm_mode_t;

  typedef struct packed {
    logic [31:0] best_id;
    logic        found;
    logic        took_this;
    logic [15:0] best_depth_out;
    logic [15:0] best_width_out;
    logic [15:0] best_height_out;
  } dmbm_result_t;

endpackage

// File: design/dmbm_if.sv
// ----------------------------------------------------------------------------
// Display mode best match: channel interfaces
// Valid/ready channels for mode beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface dmbm_mode_if import dmbm_pkg::*; ();
  logic       valid;
  logic       ready;
  dmbm_mode_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmbm_result_if import dmbm_pkg::*; ();
  logic         valid;
  logic         ready;
  dmbm_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmbm_cfg_if import dmbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: design/display_mode_best_match_top.sv
// ----------------------------------------------------------------------------
// Display mode best match: top level
// Filters offered display modes and keeps the smallest one meeting the limits.
// ----------------------------------------------------------------------------
// Path: a mode beat passes through the input register, then the filter and compare
// into the result register, which presents its result.
// Throughput: one beat per cycle unless the result sink stalls; the kept-best
// registers close their update loop as each beat advances, which sets that rate.
// Reset: registers take their documented defaults and the kept best is cleared
// to the no-mode marker; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
module display_mode_best_match_top import dmbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dmbm_cfg_if.sink         cfg_i,
  dmbm_mode_if.sink        mode_i,
  dmbm_result_if.source    result_o
);

  // Configuration registers. The port never stalls.
  logic [31:0] must_have_q;
  logic [31:0] must_not_have_q;
  logic [23:0] min_gun_bits_q;
  logic [7:0]  min_depth_q;
  logic [15:0] min_width_q;
  logic [15:0] min_height_q;
  logic [31:0] req_mode_id_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      must_have_q     <= MustHaveRst;
      must_not_have_q <= MustNotHaveRst;
      min_gun_bits_q  <= MinGunBitsRst;
      min_depth_q     <= MinDepthRst;
      min_width_q     <= MinWidthRst;
      min_height_q    <= MinHeightRst;
      req_mode_id_q   <= NoMode;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMustHave:    must_have_q     <= cfg_i.wdata;
        RegMustNotHave: must_not_have_q <= cfg_i.wdata;
        RegMinGunBits:  min_gun_bits_q  <= cfg_i.wdata[23:0];
        RegMinDepth:    min_depth_q     <= cfg_i.wdata[7:0];
        RegMinWidth:    min_width_q     <= cfg_i.wdata[15:0];
        RegMinHeight:   min_height_q    <= cfg_i.wdata[15:0];
        RegReqModeId:   req_mode_id_q   <= cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  // Stage one holds the accepted beat. It moves on whenever the result
  // register is empty or being drained, so the input takes a new beat every
  // cycle unless the output side stalls.
  logic       s1_valid_q;
  dmbm_mode_t s1_q;
  logic       out_valid_q;
  logic       advance;

  assign advance      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign mode_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (mode_i.ready) begin
      s1_valid_q <= mode_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mode_i.valid && mode_i.ready) begin
      s1_q <= mode_i.data;
    end
  end

  // Filter and size compare on the staged beat. The kept best is updated in
  // the same cycle the beat moves into the result register, so the next beat
  // in stage one always compares against an up-to-date best.
  logic [31:0] kept_id_q;
  logic [15:0] kept_depth_q;
  logic [15:0] kept_width_q;
  logic [15:0] kept_height_q;

  logic [31:0] forbid;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] depth;
  logic        id_ok;
  logic        flags_ok;
  logic        guns_ok;
  logic        mins_ok;
  logic        acceptable;
  logic        no_larger;
  logic        smaller;
  logic        take;

  always_comb begin
    forbid = must_not_have_q & ~must_have_q;
    width  = s1_q.right_x - s1_q.left_x + 16'd1;
    height = s1_q.bottom_y - s1_q.top_y + 16'd1;
    depth  = {8'd0, s1_q.max_depth};

    // The all-ones ID marks "no mode" and can never be kept.
    id_ok = (s1_q.mode_id != NoMode)
         && ((req_mode_id_q == NoMode) || (req_mode_id_q == s1_q.mode_id));
    flags_ok = ((s1_q.property_flags & forbid) == 32'd0)
            && ((s1_q.property_flags & must_have_q) == must_have_q);
    guns_ok = (s1_q.red_bits   >= min_gun_bits_q[23:16])
           && (s1_q.green_bits >= min_gun_bits_q[15:8])
           && (s1_q.blue_bits  >= min_gun_bits_q[7:0]);
    mins_ok = (s1_q.max_depth >= min_depth_q)
           && (width >= min_width_q)
           && (height >= min_height_q);
    acceptable = id_ok && !s1_q.unavailable && flags_ok && guns_ok && mins_ok;

    // A mode equal in all three sizes does not replace the kept one.
    no_larger = (depth <= kept_depth_q) && (width <= kept_width_q)
             && (height <= kept_height_q);
    smaller   = (depth < kept_depth_q) || (width < kept_width_q)
             || (height < kept_height_q);
    take = (s1_q.cmd == CmdOffer) && acceptable && no_larger && smaller;
  end

  logic [31:0] kept_id_d;
  logic [15:0] kept_depth_d;
  logic [15:0] kept_width_d;
  logic [15:0] kept_height_d;

  always_comb begin
    kept_id_d     = kept_id_q;
    kept_depth_d  = kept_depth_q;
    kept_width_d  = kept_width_q;
    kept_height_d = kept_height_q;
    if (s1_q.cmd == CmdClear) begin
      kept_id_d     = NoMode;
      kept_depth_d  = KeptSizeRst;
      kept_width_d  = KeptSizeRst;
      kept_height_d = KeptSizeRst;
    end else if (take) begin
      kept_id_d     = s1_q.mode_id;
      kept_depth_d  = depth;
      kept_width_d  = width;
      kept_height_d = height;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_id_q     <= NoMode;
      kept_depth_q  <= KeptSizeRst;
      kept_width_q  <= KeptSizeRst;
      kept_height_q <= KeptSizeRst;
    end else if (advance) begin
      kept_id_q     <= kept_id_d;
      kept_depth_q  <= kept_depth_d;
      kept_width_q  <= kept_width_d;
      kept_height_q <= kept_height_d;
    end
  end

  // Result register: holds the beat until the sink takes it.
  dmbm_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.best_id         <= kept_id_d;
      out_q.found           <= (kept_id_d != NoMode);
      out_q.took_this       <= take;
      out_q.best_depth_out  <= kept_depth_d;
      out_q.best_width_out  <= kept_width_d;
      out_q.best_height_out <= kept_height_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule
